[rtl/ovn_pkg.sv]
// Shared types, codes and constants of the octave value noise block.
`default_nettype none

package ovn_pkg;

  // Divider geometry: divisor, partial remainder, dividend/quotient shift word.
  localparam int DIV_W  = 40;
  localparam int REM_W  = 41;
  localparam int SR_W   = 64;
  localparam int STEP_W = 6;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Defaults for the top level parameters.
  localparam int MAX_WIDTH_DEF   = 256;
  localparam int MAX_HEIGHT_DEF  = 256;
  localparam int MAX_OCTAVES_DEF = 16;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OCTAVES  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FALLOFF  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WDIVISOR = 3'd4;

  // Register reset values.
  localparam logic [8:0]  RST_WIDTH    = 9'd256;
  localparam logic [8:0]  RST_HEIGHT   = 9'd256;
  localparam logic [4:0]  RST_OCTAVES  = 5'd8;
  localparam logic [15:0] RST_FALLOFF  = 16'd128;
  localparam logic [15:0] RST_WDIVISOR = 16'd512;

  // Operation codes.
  localparam logic [1:0] OP_LINE_WR  = 2'd0;
  localparam logic [1:0] OP_PLANE_WR = 2'd1;
  localparam logic [1:0] OP_LINE_Q   = 2'd2;
  localparam logic [1:0] OP_PLANE_Q  = 2'd3;

  // Fixed point constants.
  localparam logic [31:0] ONE_Q16   = 32'h0001_0000;
  localparam logic [23:0] PITCH_MAX = 24'hFF_FFFF;

  // Division jobs run on the shared divider.
  typedef enum logic [2:0] {
    JOB_MODX,
    JOB_MODY,
    JOB_LATQ,
    JOB_WRAP,
    JOB_BLEND,
    JOB_WEIGHT,
    JOB_MEAN
  } job_t;

  // Datapath actions.
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_INIT,
    ACT_WRITE,
    ACT_LM_T,
    ACT_LA_T,
    ACT_LM_B,
    ACT_LA_B,
    ACT_LM_Y,
    ACT_LA_Y,
    ACT_ACC_M,
    ACT_ACC_A
  } act_t;

  typedef struct packed {
    logic       load;
    logic       div_start;
    job_t       job;
    logic       axis;
    act_t       act;
    logic [1:0] rd_sel;
    logic       cap_en;
    logic [1:0] cap_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic is_write;
    logic is_plane;
    logic last_octave;
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/octave_value_noise.sv]
// Top level of the octave value noise block.
`default_nettype none

// Usage: an item (operation, x_coord, y_coord, seed_value) is taken at a clock
// edge where start is high and busy is low. Busy stays high until the item is
// finished. A seed write stores one seed and gives no result; its busy time is
// spent mostly in the two coordinate reductions on the divider.
// A query returns noise_value with a one cycle done strobe; busy is low in the
// same cycle, so a new item may start right away. The receiver cannot stall.
// Most of the busy time of a query goes to the shared divider, which retires
// one quotient bit a cycle: lattice quotient, wrap and blend per axis and octave,
// then the weight division between octaves and a final 16 step mean division.
// Configuration writes are taken on the cfg channel whenever not in reset;
// they are meant for idle periods only. Synchronous reset restores the default
// register values and returns the controller to idle; seed memories keep their
// contents and are undefined until written.
module octave_value_noise import ovn_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
  parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            operation,
  input  wire logic [31:0]           x_coord,
  input  wire logic [31:0]           y_coord,
  input  wire logic [15:0]           seed_value,
  output logic                       done,
  output logic      [15:0]           noise_value,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  ovn_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  ovn_datapath #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .MAX_OCTAVES (MAX_OCTAVES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .operation   (operation),
    .x_coord     (x_coord),
    .y_coord     (y_coord),
    .seed_value  (seed_value),
    .cmd         (cmd),
    .status      (status),
    .noise_value (noise_value),
    .done        (done)
  );

`ifndef ASSERT_OFF
  // A result only ends a query that was in progress.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a query in progress");

  // The block is idle while a result is shown.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("busy while a result is shown");

  // An accepted item makes the block busy.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // Each query gives one result strobe, never two in a row.
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");
`endif

endmodule

`default_nettype wire

[rtl/ovn_div.sv]
// Restoring divider that retires one quotient bit per cycle.
`default_nettype none

module ovn_div import ovn_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [REM_W-1:0]  rem0,
  input  wire logic [SR_W-1:0]   sr0,
  input  wire logic [DIV_W-1:0]  den,
  input  wire logic [STEP_W-1:0] steps,
  output logic      [REM_W-1:0]  rem,
  output logic      [SR_W-1:0]   sr,
  output logic                   done
);

  logic              running;
  logic [STEP_W-1:0] cnt;
  logic [STEP_W-1:0] last;
  logic [DIV_W-1:0]  dsr;
  logic [REM_W-1:0]  trial;
  logic              ge;

  // Shift in the next dividend bit and try the subtraction.
  assign trial = {rem[REM_W-2:0], sr[SR_W-1]};
  assign ge    = (trial >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem     <= rem0;
        sr      <= sr0;
        dsr     <= den;
        cnt     <= '0;
        last    <= steps - 1'b1;
        running <= 1'b1;
      end else if (running) begin
        rem <= ge ? (trial - {1'b0, dsr}) : trial;
        sr  <= {sr[SR_W-2:0], ge};
        cnt <= cnt + 1'b1;
        if (cnt == last) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/ovn_datapath.sv]
// Datapath: configuration, seed memories, lattice, interpolation and sums.
`default_nettype none

module ovn_datapath import ovn_pkg::*; #(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
  parameter int MAX_OCTAVES = MAX_OCTAVES_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [1:0]            operation,
  input  wire logic [31:0]           x_coord,
  input  wire logic [31:0]           y_coord,
  input  wire logic [15:0]           seed_value,
  input  wire dp_cmd_t               cmd,
  output dp_status_t                 status,
  output logic      [15:0]           noise_value,
  output logic                       done
);

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int PW    = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int OB    = $clog2(MAX_OCTAVES + 1);
  localparam int ACC_W = 48 + OB;
  localparam int WS_W  = 32 + OB;

  // Configuration registers.
  logic [8:0]  cfg_width, cfg_height;
  logic [4:0]  cfg_octaves;
  logic [15:0] cfg_falloff, cfg_wdiv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width   <= RST_WIDTH;
      cfg_height  <= RST_HEIGHT;
      cfg_octaves <= RST_OCTAVES;
      cfg_falloff <= RST_FALLOFF;
      cfg_wdiv    <= RST_WDIVISOR;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH:    cfg_width   <= cfg_data[8:0];
        REG_HEIGHT:   cfg_height  <= cfg_data[8:0];
        REG_OCTAVES:  cfg_octaves <= cfg_data[4:0];
        REG_FALLOFF:  cfg_falloff <= cfg_data;
        REG_WDIVISOR: cfg_wdiv    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamped register values in use.
  logic [8:0]  w_c, h_c;
  logic [4:0]  n_c;
  logic [15:0] wdiv_c;

  always_comb begin
    if (cfg_width == 9'd0)                  w_c = 9'd1;
    else if (int'(cfg_width) > MAX_WIDTH)   w_c = 9'(MAX_WIDTH);
    else                                    w_c = cfg_width;
    if (cfg_height == 9'd0)                 h_c = 9'd1;
    else if (int'(cfg_height) > MAX_HEIGHT) h_c = 9'(MAX_HEIGHT);
    else                                    h_c = cfg_height;
    if (cfg_octaves == 5'd0)                n_c = 5'd1;
    else if (int'(cfg_octaves) > MAX_OCTAVES) n_c = 5'(MAX_OCTAVES);
    else                                    n_c = cfg_octaves;
    wdiv_c = (cfg_wdiv == 16'd0) ? 16'd1 : cfg_wdiv;
  end

  // Item registers and working state.
  logic [1:0]  op_q;
  logic [31:0] x_q, y_q;
  logic [15:0] seed_q;
  logic [8:0]  xm, ym;
  logic [8:0]  x1, x2, y1, y2, lr;
  logic [15:0] bx, by;
  logic [23:0] pitch;
  logic [31:0] weight;
  logic [ACC_W-1:0] acc;
  logic [WS_W-1:0]  wsum;
  logic [4:0]  oct;
  logic [15:0] s00, s01, s10, s11, t_val, b_val, smp;
  logic signed [33:0] lprod;
  logic [47:0] wprod;
  logic [39:0] pprod;

  logic is_plane;
  assign is_plane = (op_q == OP_PLANE_WR) || (op_q == OP_PLANE_Q);

  assign status.is_write    = (op_q == OP_LINE_WR) || (op_q == OP_PLANE_WR);
  assign status.is_plane    = is_plane;
  assign status.last_octave = (oct == (n_c - 5'd1));

  // Current lattice axis.
  logic [8:0] v_cur, size_cur, a_cur;
  assign v_cur    = cmd.axis ? ym : xm;
  assign size_cur = cmd.axis ? h_c : w_c;
  assign a_cur    = cmd.axis ? y1 : x1;

  // Divider operand selection per job.
  logic [REM_W-1:0]  d_rem0, d_rem;
  logic [SR_W-1:0]   d_sr0, d_sr;
  logic [DIV_W-1:0]  d_den;
  logic [STEP_W-1:0] d_steps;
  logic              d_done;
  logic [24:0]       wrap_sum;

  assign wrap_sum = 25'(a_cur) + 25'(pitch);

  always_comb begin
    d_rem0  = '0;
    d_sr0   = '0;
    d_den   = '0;
    d_steps = '0;
    case (cmd.job)
      JOB_MODX: begin
        d_sr0   = {x_q, 32'd0};
        d_den   = DIV_W'(w_c);
        d_steps = 6'd32;
      end
      JOB_MODY: begin
        d_sr0   = {y_q, 32'd0};
        d_den   = DIV_W'(h_c);
        d_steps = 6'd32;
      end
      JOB_LATQ: begin
        d_sr0   = {v_cur, {(SR_W-9){1'b0}}};
        d_den   = DIV_W'(pitch);
        d_steps = 6'd9;
      end
      JOB_WRAP: begin
        d_sr0   = {wrap_sum, {(SR_W-25){1'b0}}};
        d_den   = DIV_W'(size_cur);
        d_steps = 6'd25;
      end
      JOB_BLEND: begin
        d_rem0  = REM_W'(lr);
        d_den   = DIV_W'(pitch);
        d_steps = 6'd16;
      end
      JOB_WEIGHT: begin
        d_sr0   = {weight, 32'd0};
        d_den   = DIV_W'(wdiv_c);
        d_steps = 6'd40;
      end
      JOB_MEAN: begin
        d_rem0  = REM_W'(acc[ACC_W-1:16]);
        d_sr0   = {acc[15:0], 48'd0};
        d_den   = DIV_W'(wsum);
        d_steps = 6'd16;
      end
      default: ;
    endcase
  end

  ovn_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .rem0  (d_rem0),
    .sr0   (d_sr0),
    .den   (d_den),
    .steps (d_steps),
    .rem   (d_rem),
    .sr    (d_sr),
    .done  (d_done)
  );

  assign status.div_done = d_done;

  // Lerp operands: a + floor((c - a) * b / 65536).
  logic [15:0] la, lc, lb;
  logic signed [16:0] ldiff;
  logic signed [18:0] lsum;
  logic [15:0] lres;

  always_comb begin
    case (cmd.act)
      ACT_LM_B, ACT_LA_B: begin
        la = s10;   lc = s11;   lb = bx;
      end
      ACT_LM_Y, ACT_LA_Y: begin
        la = t_val; lc = b_val; lb = by;
      end
      default: begin
        la = s00;   lc = s01;   lb = bx;
      end
    endcase
  end

  assign ldiff = $signed({1'b0, lc}) - $signed({1'b0, la});
  assign lsum  = 19'($signed({3'b000, la})) + 19'($signed(lprod[33:16]));
  assign lres  = lsum[15:0];

  // Seed memories.
  logic [15:0] line_mem  [MAX_WIDTH];
  logic [15:0] plane_mem [MAX_WIDTH*MAX_HEIGHT];
  logic [15:0] l_q, p_q;
  logic [8:0]  rx, ry;
  logic [XW-1:0] l_addr;
  logic [PW-1:0] p_addr;
  logic          wr_now;

  assign wr_now = (cmd.act == ACT_WRITE);
  assign rx     = wr_now ? xm : (cmd.rd_sel[0] ? x2 : x1);
  assign ry     = wr_now ? ym : (cmd.rd_sel[1] ? y2 : y1);
  assign l_addr = XW'(rx);
  assign p_addr = PW'(ry) * PW'(MAX_WIDTH) + PW'(rx);

  always_ff @(posedge clk) begin
    if (wr_now && (op_q == OP_LINE_WR)) line_mem[l_addr] <= seed_q;
    l_q <= line_mem[l_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_now && (op_q == OP_PLANE_WR)) plane_mem[p_addr] <= seed_q;
    p_q <= plane_mem[p_addr];
  end

  // Working registers.
  logic [8:0] r_new;
  assign r_new = d_rem[8:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= operation;
      x_q    <= x_coord;
      y_q    <= y_coord;
      seed_q <= seed_value;
    end

    // Corner seed captures.
    if (cmd.cap_en) begin
      case (cmd.cap_sel)
        2'd0:    s00 <= is_plane ? p_q : l_q;
        2'd1:    s01 <= is_plane ? p_q : l_q;
        2'd2:    s10 <= is_plane ? p_q : l_q;
        default: s11 <= is_plane ? p_q : l_q;
      endcase
    end

    case (cmd.act)
      ACT_INIT: begin
        pitch  <= 24'(w_c);
        weight <= ONE_Q16;
        acc    <= '0;
        wsum   <= '0;
        oct    <= '0;
      end
      ACT_LM_T, ACT_LM_B, ACT_LM_Y: lprod <= ldiff * $signed({1'b0, lb});
      ACT_LA_T: begin
        t_val <= lres;
        smp   <= lres;
      end
      ACT_LA_B: b_val <= lres;
      ACT_LA_Y: smp   <= lres;
      ACT_ACC_M: begin
        wprod <= smp * weight;
        pprod <= pitch * cfg_falloff;
      end
      ACT_ACC_A: begin
        acc   <= acc + ACC_W'(wprod);
        wsum  <= wsum + WS_W'(weight);
        pitch <= (|pprod[39:32]) ? PITCH_MAX : pprod[31:8];
      end
      default: ;
    endcase

    // Results of the divider, by job.
    if (d_done) begin
      case (cmd.job)
        JOB_MODX: xm <= r_new;
        JOB_MODY: ym <= r_new;
        JOB_LATQ: begin
          lr <= r_new;
          if (cmd.axis) y1 <= (pitch == 24'd0) ? v_cur : v_cur - r_new;
          else          x1 <= (pitch == 24'd0) ? v_cur : v_cur - r_new;
        end
        JOB_WRAP: begin
          if (cmd.axis) y2 <= r_new;
          else          x2 <= r_new;
        end
        JOB_BLEND: begin
          if (cmd.axis) by <= (pitch == 24'd0) ? 16'd0 : d_sr[15:0];
          else          bx <= (pitch == 24'd0) ? 16'd0 : d_sr[15:0];
        end
        JOB_WEIGHT: begin
          weight <= (|d_sr[39:32]) ? 32'hFFFF_FFFF : d_sr[31:0];
          oct    <= oct + 5'd1;
        end
        JOB_MEAN: noise_value <= d_sr[15:0];
        default: ;
      endcase
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= d_done && (cmd.job == JOB_MEAN);
    end
  end

endmodule

`default_nettype wire

[rtl/ovn_ctrl.sv]
// Controller: sequences divider jobs, memory reads, lerps and octave sums.
`default_nettype none

module ovn_ctrl import ovn_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd,
  output logic            busy
);

  typedef enum logic [18:0] {
    S_IDLE     = 19'h00001,
    S_DIV_GO   = 19'h00002,
    S_DIV_WAIT = 19'h00004,
    S_WRITE    = 19'h00008,
    S_INIT     = 19'h00010,
    S_RD0      = 19'h00020,
    S_RD1      = 19'h00040,
    S_RD2      = 19'h00080,
    S_RD3      = 19'h00100,
    S_RD4      = 19'h00200,
    S_LM_T     = 19'h00400,
    S_LA_T     = 19'h00800,
    S_LM_B     = 19'h01000,
    S_LA_B     = 19'h02000,
    S_LM_Y     = 19'h04000,
    S_LA_Y     = 19'h08000,
    S_ACC_M    = 19'h10000,
    S_ACC_A    = 19'h20000,
    S_NEXT     = 19'h40000
  } state_t;

  state_t state, state_next;
  job_t   job, job_next;
  logic   axis, axis_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      job   <= JOB_MODX;
      axis  <= 1'b0;
    end else begin
      state <= state_next;
      job   <= job_next;
      axis  <= axis_next;
    end
  end

  assign busy = (state != S_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    job_next   = job;
    axis_next  = axis;
    cmd        = '0;
    cmd.job    = job;
    cmd.axis   = axis;
    cmd.act    = ACT_NONE;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          job_next   = JOB_MODX;
          state_next = S_DIV_GO;
        end
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (status.div_done) begin
          case (job)
            JOB_MODX: begin
              job_next   = JOB_MODY;
              state_next = S_DIV_GO;
            end
            JOB_MODY:  state_next = status.is_write ? S_WRITE : S_INIT;
            JOB_LATQ: begin
              job_next   = JOB_WRAP;
              state_next = S_DIV_GO;
            end
            JOB_WRAP: begin
              job_next   = JOB_BLEND;
              state_next = S_DIV_GO;
            end
            JOB_BLEND: begin
              if (status.is_plane && !axis) begin
                axis_next  = 1'b1;
                job_next   = JOB_LATQ;
                state_next = S_DIV_GO;
              end else begin
                state_next = S_RD0;
              end
            end
            JOB_WEIGHT: begin
              axis_next  = 1'b0;
              job_next   = JOB_LATQ;
              state_next = S_DIV_GO;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_WRITE: begin
        cmd.act    = ACT_WRITE;
        state_next = S_IDLE;
      end
      S_INIT: begin
        cmd.act    = ACT_INIT;
        axis_next  = 1'b0;
        job_next   = JOB_LATQ;
        state_next = S_DIV_GO;
      end
      // Corner reads: address in one cycle, capture in the next.
      S_RD0: begin
        cmd.rd_sel = 2'd0;
        state_next = S_RD1;
      end
      S_RD1: begin
        cmd.rd_sel  = 2'd1;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = 2'd0;
        state_next  = S_RD2;
      end
      S_RD2: begin
        cmd.rd_sel  = 2'd2;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = 2'd1;
        state_next  = status.is_plane ? S_RD3 : S_LM_T;
      end
      S_RD3: begin
        cmd.rd_sel  = 2'd3;
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = 2'd2;
        state_next  = S_RD4;
      end
      S_RD4: begin
        cmd.cap_en  = 1'b1;
        cmd.cap_sel = 2'd3;
        state_next  = S_LM_T;
      end
      S_LM_T: begin
        cmd.act    = ACT_LM_T;
        state_next = S_LA_T;
      end
      S_LA_T: begin
        cmd.act    = ACT_LA_T;
        state_next = status.is_plane ? S_LM_B : S_ACC_M;
      end
      S_LM_B: begin
        cmd.act    = ACT_LM_B;
        state_next = S_LA_B;
      end
      S_LA_B: begin
        cmd.act    = ACT_LA_B;
        state_next = S_LM_Y;
      end
      S_LM_Y: begin
        cmd.act    = ACT_LM_Y;
        state_next = S_LA_Y;
      end
      S_LA_Y: begin
        cmd.act    = ACT_LA_Y;
        state_next = S_ACC_M;
      end
      S_ACC_M: begin
        cmd.act    = ACT_ACC_M;
        state_next = S_ACC_A;
      end
      S_ACC_A: begin
        cmd.act    = ACT_ACC_A;
        state_next = S_NEXT;
      end
      // After the last octave only the mean is left to divide.
      S_NEXT: begin
        job_next   = status.last_octave ? JOB_MEAN : JOB_WEIGHT;
        state_next = S_DIV_GO;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire
